### rtl/bresenham_line_stepper_defines.svh
// Assertion helpers shared by the RTL of the line stepper.
// In a synthesis build every macro expands to nothing.
`ifndef BRESENHAM_LINE_STEPPER_DEFINES_SVH
`define BRESENHAM_LINE_STEPPER_DEFINES_SVH

`ifndef SYNTHESIS

// Property checked at every rising edge, switched off while reset is low.
`define BLS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define BLS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define BLS_ASSERT(lbl, clk, rstn, prop, msg)
`define BLS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

### rtl/bls_pkg.sv
package bls_pkg;

    // Request kinds carried on the slave side tuser.
    typedef enum logic [0:0] {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } t_op;

    // Depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 2;

endpackage

### rtl/bls_front.sv
module bls_front #(
    parameter int COORD_BITS = 11
) (
    input  logic                      i_op,
    input  logic [COORD_BITS-1:0]     i_start_x,
    input  logic [COORD_BITS-1:0]     i_start_y,
    input  logic [COORD_BITS-1:0]     i_end_x,
    input  logic [COORD_BITS-1:0]     i_end_y,
    output logic [5*COORD_BITS+2:0]   o_cmd
);
    import bls_pkg::*;

    typedef struct packed {
        t_op                   op;
        logic                  steep;
        logic                  neg;
        logic [COORD_BITS-1:0] maj0;
        logic [COORD_BITS-1:0] min0;
        logic [COORD_BITS-1:0] maj_end;
        logic [COORD_BITS-1:0] dmaj;
        logic [COORD_BITS-1:0] dmin;
    } t_cmd;

    logic                  x_gt;
    logic                  x_lt;
    logic                  y_gt;
    logic                  y_lt;
    logic [COORD_BITS-1:0] adx;
    logic [COORD_BITS-1:0] ady;
    t_cmd                  cmd;

    // Absolute deltas and the ordering of each coordinate pair.
    always_comb begin
        x_gt = i_start_x > i_end_x;
        x_lt = i_start_x < i_end_x;
        y_gt = i_start_y > i_end_y;
        y_lt = i_start_y < i_end_y;
        adx  = x_gt ? (i_start_x - i_end_x) : (i_end_x - i_start_x);
        ady  = y_gt ? (i_start_y - i_end_y) : (i_end_y - i_start_y);
    end

    // Classify the line and put the endpoints in walking order along the major axis.
    // Equal deltas count as steep, so a single-point line is steep as well.
    always_comb begin
        cmd       = '0;
        cmd.op    = t_op'(i_op);
        cmd.steep = !(ady < adx);
        if (!cmd.steep) begin
            cmd.dmaj    = adx;
            cmd.dmin    = ady;
            cmd.maj0    = x_gt ? i_end_x   : i_start_x;
            cmd.min0    = x_gt ? i_end_y   : i_start_y;
            cmd.maj_end = x_gt ? i_start_x : i_end_x;
            cmd.neg     = x_gt ? y_lt      : y_gt;
        end else begin
            cmd.dmaj    = ady;
            cmd.dmin    = adx;
            cmd.maj0    = y_gt ? i_end_y   : i_start_y;
            cmd.min0    = y_gt ? i_end_x   : i_start_x;
            cmd.maj_end = y_gt ? i_start_y : i_end_y;
            cmd.neg     = y_gt ? x_lt      : x_gt;
        end
    end

    assign o_cmd = cmd;

endmodule

### rtl/bls_queue.sv
module bls_queue #(
    parameter int DATA_W = 58
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_not_full,
    input  logic              i_pop,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data
);
    import bls_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              do_push;
    logic              do_pop;

    assign o_not_full = r_count != CNT_W'(QUEUE_DEPTH);
    assign o_valid    = r_count != '0;
    assign o_data     = r_mem[r_rd_ptr];
    assign do_push    = i_push && o_not_full;
    assign do_pop     = i_pop && o_valid;

    // Storage, pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### rtl/bls_back.sv
`include "bresenham_line_stepper_defines.svh"

module bls_back #(
    parameter int COORD_BITS = 11
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cmd_valid,
    input  logic [5*COORD_BITS+2:0]   i_cmd,
    output logic                      o_cmd_pop,
    output logic                      o_pix_valid,
    input  logic                      i_pix_ready,
    output logic [COORD_BITS-1:0]     o_pixel_x,
    output logic [COORD_BITS-1:0]     o_pixel_y,
    output logic                      o_last_pixel
);
    import bls_pkg::*;

    localparam int DEC_W = COORD_BITS + 3;

    typedef struct packed {
        t_op                   op;
        logic                  steep;
        logic                  neg;
        logic [COORD_BITS-1:0] maj0;
        logic [COORD_BITS-1:0] min0;
        logic [COORD_BITS-1:0] maj_end;
        logic [COORD_BITS-1:0] dmaj;
        logic [COORD_BITS-1:0] dmin;
    } t_cmd;

    t_cmd                     cmd;
    logic                     r_active;
    logic                     r_steep;
    logic                     r_neg;
    logic [COORD_BITS-1:0]    r_maj;
    logic [COORD_BITS-1:0]    r_min;
    logic [COORD_BITS-1:0]    r_end;
    logic [COORD_BITS-1:0]    r_dmaj;
    logic [COORD_BITS-1:0]    r_dmin;
    logic signed [DEC_W-1:0]  r_dec;
    logic                     r_ovalid;
    logic [COORD_BITS-1:0]    r_ox;
    logic [COORD_BITS-1:0]    r_oy;
    logic                     r_olast;

    logic                     out_free;
    logic                     is_start;
    logic                     emit;
    logic                     at_end;
    logic signed [DEC_W-1:0]  two_dmin;
    logic signed [DEC_W-1:0]  two_dmaj;
    logic signed [DEC_W-1:0]  n_dec;
    logic signed [DEC_W-1:0]  start_dec;
    logic [COORD_BITS-1:0]    n_min;

    assign cmd      = i_cmd;
    assign out_free = !r_ovalid || i_pix_ready;
    assign is_start = cmd.op == OP_START;
    assign at_end   = r_maj == r_end;

    // A start or an idle step retires at once; a live step waits for the output slot.
    assign emit      = i_cmd_valid && !is_start && r_active && out_free;
    assign o_cmd_pop = i_cmd_valid && (is_start || !r_active || out_free);

    // Decision term arithmetic.
    always_comb begin
        two_dmin  = DEC_W'({r_dmin, 1'b0});
        two_dmaj  = DEC_W'({r_dmaj, 1'b0});
        start_dec = DEC_W'({cmd.dmin, 1'b0}) - DEC_W'(cmd.dmaj);
        if (r_dec > 0) begin
            n_dec = r_dec + (two_dmin - two_dmaj);
            n_min = r_neg ? r_min - 1'b1 : r_min + 1'b1;
        end else begin
            n_dec = r_dec + two_dmin;
            n_min = r_min;
        end
    end

    // Line state and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd_valid && is_start) begin
                r_active <= 1'b1;
                r_steep  <= cmd.steep;
                r_neg    <= cmd.neg;
                r_maj    <= cmd.maj0;
                r_min    <= cmd.min0;
                r_end    <= cmd.maj_end;
                r_dmaj   <= cmd.dmaj;
                r_dmin   <= cmd.dmin;
                r_dec    <= start_dec;
            end else if (emit) begin
                if (at_end) begin
                    r_active <= 1'b0;
                end else begin
                    r_maj <= r_maj + 1'b1;
                    r_min <= n_min;
                    r_dec <= n_dec;
                end
            end

            if (emit) begin
                r_ovalid <= 1'b1;
                r_ox     <= r_steep ? r_min : r_maj;
                r_oy     <= r_steep ? r_maj : r_min;
                r_olast  <= at_end;
            end else if (i_pix_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_pix_valid  = r_ovalid;
    assign o_pixel_x    = r_ox;
    assign o_pixel_y    = r_oy;
    assign o_last_pixel = r_olast;

    // The decision term stays between minus twice the major extent and twice the minor one.
    `BLS_ASSERT(a_dec_range, i_clk, i_rst_n, r_active |-> (r_dec >= -two_dmaj && r_dec <= two_dmin), "decision term out of range")
    // The walk never passes the final major coordinate.
    `BLS_ASSERT(a_major_bound, i_clk, i_rst_n, r_active |-> (r_maj <= r_end), "major coordinate passed the end")
    // Emitting the final pixel leaves the block idle.
    `BLS_ASSERT_NEXT(a_idle_after_last, i_clk, i_rst_n, emit && at_end, !r_active && r_olast, "line still active after last pixel")

endmodule

### rtl/bresenham_line_stepper.sv
// Channel    Direction  Fields (lowest bit first)
// s_axis     in         tuser: op; tdata: start_x, start_y, end_x, end_y
// m_axis     out        tdata: pixel_x, pixel_y; tlast: last_pixel
//
// One request is taken per clock while the command queue has room. A live step loads
// its pixel into the output register at the edge that takes it from the command queue.
// The rate is set by the back end's step unit: one add and compare per pixel.
// Reset (synchronous, active low) empties the queue and leaves the block idle.
// A stalled output holds its pixel; the two-entry queue absorbs the stall
// before s_axis tready falls.
module bresenham_line_stepper #(
    parameter int COORD_BITS = 11
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // start_x, start_y, end_x, end_y, zero padding
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]     i_s_axis_tdata,
    // op
    input  logic                                  i_s_axis_tuser,
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // pixel_x, pixel_y, zero padding
    output logic [((2*COORD_BITS+7)/8)*8-1:0]     o_m_axis_tdata,
    output logic                                  o_m_axis_tlast
);
    import bls_pkg::*;

    localparam int CMD_W  = 5 * COORD_BITS + 3;
    localparam int OUT_W  = ((2 * COORD_BITS + 7) / 8) * 8;

    logic [CMD_W-1:0]      front_cmd;
    logic [CMD_W-1:0]      q_cmd;
    logic                  q_valid;
    logic                  q_pop;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;

    // Classify each request as it arrives.
    bls_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_op       (i_s_axis_tuser),
        .i_start_x  (i_s_axis_tdata[COORD_BITS-1:0]),
        .i_start_y  (i_s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .i_end_x    (i_s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]),
        .i_end_y    (i_s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS]),
        .o_cmd      (front_cmd)
    );

    // Command queue between the two halves.
    bls_queue #(
        .DATA_W     (CMD_W)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_s_axis_tvalid),
        .i_data     (front_cmd),
        .o_not_full (o_s_axis_tready),
        .i_pop      (q_pop),
        .o_valid    (q_valid),
        .o_data     (q_cmd)
    );

    // Line walker and output register.
    bls_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (q_valid),
        .i_cmd        (q_cmd),
        .o_cmd_pop    (q_pop),
        .o_pix_valid  (o_m_axis_tvalid),
        .i_pix_ready  (i_m_axis_tready),
        .o_pixel_x    (pixel_x),
        .o_pixel_y    (pixel_y),
        .o_last_pixel (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = OUT_W'({pixel_y, pixel_x});

endmodule
